// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL; clocked on clock, RAD_ASSERT idle in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled at the rising clock edge, disabled during reset.
`define RAD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same check, but also evaluated while reset is high.
`define RAD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/core/rad_pkg.sv =====
package rad_pkg;

   localparam int RES_W    = 6;
   localparam int PROFIT_W = 16;
   localparam int BEST_W   = 23;
   localparam int ACC_W    = BEST_W + 1;
   localparam int SUM_W    = BEST_W + 2;

   localparam logic [BEST_W-1:0] BEST_MAX = {BEST_W{1'b1}};

   localparam int MAX_RESOURCES_DEF = 64;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                       fire;      // transaction accepted this cycle
      logic                       complete;  // this transaction closes the row
      logic                       clear;     // closing row is the final project
      logic [RES_W-1:0]           resources;
      logic signed [PROFIT_W-1:0] profit;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/resource_allocation_dp.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_profit, req_last_project
// rsp       out        rsp_valid / rsp_ready  rsp_best_profit
// csr       in         csr_valid / csr_ready  csr_resources
//
// One profit entry is folded per cycle while req_ready is high: each cell keeps
// its running maximum and passes the old best row one place along the chain on
// every transaction that does not close the row. A row has resources+1 entries;
// the row update lands with the last, so the next row can follow in the next
// cycle. Reset (synchronous) clears the best row, column counter, budget register
// and result valid flag at once. req_ready drops only while a result sits unread.
`include "assert_macros.svh"

module resource_allocation_dp #(
   parameter int MAX_RESOURCES = rad_pkg::MAX_RESOURCES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rad_pkg::PROFIT_W-1:0] req_profit,
   input  logic                                req_last_project,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rad_pkg::BEST_W-1:0]          rsp_best_profit,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rad_pkg::RES_W-1:0]           csr_resources
);

   logic [rad_pkg::RES_W-1:0]  resources_ff, resources_in;
   logic [rad_pkg::RES_W-1:0]  column_ff, column_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rad_pkg::BEST_W-1:0] rsp_best_ff, rsp_best_in;
   logic                       req_fire;
   logic                       row_done;
   logic [rad_pkg::BEST_W-1:0] pick;
   rad_pkg::cell_ctrl_type     ctrl;

   logic [rad_pkg::BEST_W-1:0] shv   [MAX_RESOURCES];
   logic                       shok  [MAX_RESOURCES];
   logic [rad_pkg::BEST_W-1:0] fold  [MAX_RESOURCES];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign row_done  = (column_ff >= resources_ff);

   always_comb begin
      ctrl.fire      = req_fire;
      ctrl.complete  = row_done;
      ctrl.clear     = req_last_project;
      ctrl.resources = resources_ff;
      ctrl.profit    = req_profit;
   end

   for (genvar g = 0; g < MAX_RESOURCES; g++) begin : g_cell
      logic [rad_pkg::BEST_W-1:0] left_value;
      logic                       left_ok;
      if (g == 0) begin : g_head
         assign left_value = '0;
         assign left_ok    = 1'b0;
      end else begin : g_link
         assign left_value = shv[g-1];
         assign left_ok    = shok[g-1];
      end
      rad_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl),
         .shift_in_value  (left_value),
         .shift_in_ok     (left_ok),
         .shift_out_value (shv[g]),
         .shift_out_ok    (shok[g]),
         .fold_value      (fold[g])
      );
   end

   // select the full-budget cell; a budget past the chain reads zero
   always_comb begin
      pick = '0;
      for (int i = 0; i < MAX_RESOURCES; i++) begin
         if (i == int'(resources_ff)) begin
            pick = fold[i];
         end
      end
   end

   always_comb begin
      resources_in = resources_ff;
      column_in    = column_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_best_in  = rsp_best_ff;
      if (csr_valid && csr_ready) begin
         resources_in = csr_resources;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         if (row_done) begin
            column_in = '0;
            if (req_last_project) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = pick;
            end
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resources_ff <= '0;
         column_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         resources_ff <= resources_in;
         column_ff    <= column_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_profit = rsp_best_ff;

   `RAD_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(req_fire && row_done && req_last_project), "result without a final row")
   `RAD_ASSERT(a_col_step, (req_fire && !row_done) |=> (column_ff == $past(column_ff) + 1'b1), "column did not advance")
   `RAD_ASSERT(a_col_wrap, (req_fire && row_done) |=> (column_ff == '0), "column did not return to zero")
   `RAD_ASSERT(a_no_overrun, (rsp_valid_ff && !rsp_ready) |-> !req_fire, "transaction taken over a pending result")

endmodule

// ===== rtl/core/rad_cell.sv =====
`include "assert_macros.svh"

module rad_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rad_pkg::cell_ctrl_type       ctrl,
   input  logic [rad_pkg::BEST_W-1:0]   shift_in_value,
   input  logic                         shift_in_ok,
   output logic [rad_pkg::BEST_W-1:0]   shift_out_value,
   output logic                         shift_out_ok,
   output logic [rad_pkg::BEST_W-1:0]   fold_value
);

   logic [rad_pkg::BEST_W-1:0] best_ff, best_in;
   logic [rad_pkg::ACC_W-1:0]  acc_ff, acc_in, acc_fold;
   logic [rad_pkg::BEST_W-1:0] shv_ff, shv_in;
   logic                       shok_ff, shok_in;
   logic signed [rad_pkg::SUM_W-1:0] cand;
   logic                       hit;
   logic                       in_range;

   assign in_range = (CELL_INDEX <= int'(ctrl.resources));

   always_comb begin
      // candidate: old best[j-k] + profit[k]
      cand     = $signed({2'b00, shv_ff}) + rad_pkg::SUM_W'(ctrl.profit);
      hit      = shok_ff && (cand > $signed({1'b0, acc_ff}));
      acc_fold = hit ? cand[rad_pkg::ACC_W-1:0] : acc_ff;
      if (acc_fold > rad_pkg::ACC_W'(rad_pkg::BEST_MAX)) begin
         fold_value = rad_pkg::BEST_MAX;
      end else begin
         fold_value = acc_fold[rad_pkg::BEST_W-1:0];
      end

      best_in = best_ff;
      acc_in  = acc_ff;
      shv_in  = shv_ff;
      shok_in = shok_ff;
      if (ctrl.fire) begin
         if (ctrl.complete) begin
            if (ctrl.clear) begin
               best_in = '0;
            end else if (in_range) begin
               best_in = fold_value;
            end
            // reload the shift copy with the new row, restart the running max at the floor
            shv_in  = best_in;
            shok_in = 1'b1;
            acc_in  = '0;
         end else begin
            acc_in  = acc_fold;
            shv_in  = shift_in_value;
            shok_in = shift_in_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
         acc_ff  <= '0;
         shv_ff  <= '0;
         shok_ff <= 1'b1;
      end else begin
         best_ff <= best_in;
         acc_ff  <= acc_in;
         shv_ff  <= shv_in;
         shok_ff <= shok_in;
      end
   end

   assign shift_out_value = shv_ff;
   assign shift_out_ok    = shok_ff;

   `RAD_ASSERT(a_row_restart, (ctrl.fire && ctrl.complete) |=> (acc_ff == '0 && shok_ff && shv_ff == best_ff), "cell did not restart after row end")
   `RAD_ASSERT(a_best_clear, (ctrl.fire && ctrl.complete && ctrl.clear) |=> (best_ff == '0), "best total not cleared after final row")
   `RAD_ASSERT(a_best_hold, !ctrl.fire |=> $stable(best_ff) && $stable(acc_ff), "cell state moved without a transaction")

endmodule

// ===== tb/tb_resource_allocation_dp.sv =====
module tb_resource_allocation_dp;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET   = 1000;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum int {PROFIT_MIXED, PROFIT_GAINS, PROFIT_NEAR_MAX} profit_style_type;

   class best_total_scoreboard_type;
      logic [rad_pkg::BEST_W-1:0]          best_row[64];
      logic signed [rad_pkg::PROFIT_W-1:0] profit_row[64];
      logic [rad_pkg::RES_W-1:0]           column_index;
      logic [rad_pkg::RES_W-1:0]           resources;
      logic [rad_pkg::BEST_W-1:0]          pending_totals[$];
      int                                  errors;

      function new();
         foreach (best_row[j]) begin
            best_row[j]   = '0;
            profit_row[j] = '0;
         end
         column_index = '0;
         resources    = '0;
         errors       = 0;
      endfunction

      // Fold a completed row into the best totals; queue the budget total on a final row.
      function void note_item(logic signed [rad_pkg::PROFIT_W-1:0] profit, logic last_project);
         logic [rad_pkg::BEST_W-1:0] next_row[64];
         longint                     top;
         longint                     cand;
         profit_row[column_index] = profit;
         if (column_index < resources) begin
            column_index++;
            return;
         end
         column_index = '0;
         for (int j = 0; j <= int'(resources); j++) begin
            top = 0;
            for (int k = 0; k <= j; k++) begin
               cand = longint'(best_row[j - k]) + longint'(profit_row[k]);
               if (cand > top) top = cand;
            end
            if (top > longint'(rad_pkg::BEST_MAX)) top = longint'(rad_pkg::BEST_MAX);
            next_row[j] = top[rad_pkg::BEST_W-1:0];
         end
         for (int j = 0; j <= int'(resources); j++) best_row[j] = next_row[j];
         if (last_project) begin
            pending_totals = {pending_totals, best_row[resources]};
            foreach (best_row[j]) best_row[j] = '0;
         end
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [rad_pkg::BEST_W-1:0] got);
         logic [rad_pkg::BEST_W-1:0] want;
         if (pending_totals.size() == 0) begin
            report_mismatch($sformatf("best_profit %0d with no total pending", got));
            return;
         end
         want = pending_totals.pop_front();
         if (got !== want)
            report_mismatch($sformatf("best_profit got %0d want %0d", got, want));
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [rad_pkg::PROFIT_W-1:0] req_profit;
   logic                                req_last_project;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [rad_pkg::BEST_W-1:0]          rsp_best_profit;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [rad_pkg::RES_W-1:0]           csr_resources;

   best_total_scoreboard_type sb;
   int items_sent   = 0;
   int req_gap_pct  = 0;
   int rsp_gap_pct  = 0;
   int cycle_count  = 0;

   resource_allocation_dp dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_profit       (req_profit),
      .req_last_project (req_last_project),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_best_profit  (rsp_best_profit),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_resources    (csr_resources)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_best_profit);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && $urandom_range(1, 100) <= rsp_gap_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_item(logic signed [rad_pkg::PROFIT_W-1:0] profit, logic last_project);
      if ($urandom_range(1, 100) <= req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_profit       <= profit;
      req_last_project <= last_project;
      do @(posedge clock); while (!req_ready);
      sb.note_item(profit, last_project);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_row(int entries, logic final_row, profit_style_type style_now);
      logic signed [rad_pkg::PROFIT_W-1:0] profit;
      for (int k = 0; k < entries; k++) begin
         if (style_now == PROFIT_NEAR_MAX)
            profit = rad_pkg::PROFIT_W'(32767 - $urandom_range(0, 200));
         else if (style_now == PROFIT_GAINS || $urandom_range(0, 1) == 1)
            profit = rad_pkg::PROFIT_W'($urandom_range(0, 3000));
         else
            profit = rad_pkg::PROFIT_W'($urandom());
         // last_project only matters on the closing entry
         send_item(profit, (k == entries - 1) ? final_row : 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic write_resources(logic [rad_pkg::RES_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending_totals.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_resources <= value;
      do @(posedge clock); while (!csr_ready);
      sb.resources = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int resources_now;
      int problems;
      int rows;
      int phase;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_profit       = '0;
      req_last_project = 1'b0;
      csr_valid        = 1'b0;
      csr_resources    = '0;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      req_gap_pct = 20;
      rsp_gap_pct = 20;

      // one-entry rows at the reset width; a negative row floors at zero
      send_item(16'sh8000, 1'b1);
      send_item(16'sh7fff, 1'b1);
      send_item(16'sd0, 1'b0);
      send_item(16'sd5, 1'b1);

      write_resources(6'd3);
      send_item(16'sd10, 1'b1);
      send_item(16'sd20, 1'b0);
      send_item(-16'sd5, 1'b1);
      send_item(16'sd7, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh7fff, 1'b0);
      send_item(16'sd100, 1'b0);
      send_item(16'sd0, 1'b1);

      // shrink mid-row with the column already past the new width
      send_item(16'sd40, 1'b0);
      send_item(16'sd9, 1'b0);
      send_item(16'sd3, 1'b0);
      write_resources(6'd1);
      send_item(16'sd1, 1'b1);

      // widen mid-row
      send_item(16'sd11, 1'b0);
      write_resources(6'd4);
      send_item(16'sd2, 1'b1);
      send_item(-16'sd1, 1'b0);
      send_item(16'sd300, 1'b0);
      send_item(16'sd8, 1'b1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET * 4 / 5) begin
            req_gap_pct = 0;
            rsp_gap_pct = 0;
         end else if (phase % 3 == 2) begin
            req_gap_pct = 0;
            rsp_gap_pct = 0;
         end else begin
            req_gap_pct = $urandom_range(5, 40);
            rsp_gap_pct = $urandom_range(5, 40);
         end
         case (phase % 6)
            0:       resources_now = 63;
            1:       resources_now = 0;
            3:       resources_now = $urandom_range(0, 63);
            default: resources_now = $urandom_range(1, 6);
         endcase
         write_resources(rad_pkg::RES_W'(resources_now));
         if (phase == 1) begin
            // push the budget total into saturation
            for (int r = 0; r < 300; r++) send_row(1, r == 299, PROFIT_NEAR_MAX);
         end else if (resources_now > 15) begin
            rows = $urandom_range(1, 2);
            for (int r = 0; r < rows; r++)
               send_row(resources_now + 1, r == rows - 1,
                        profit_style_type'($urandom_range(0, 1)));
         end else begin
            problems = $urandom_range(3, 8);
            for (int p = 0; p < problems; p++) begin
               rows = $urandom_range(1, 5);
               for (int r = 0; r < rows; r++)
                  send_row(resources_now + 1, r == rows - 1,
                           profit_style_type'($urandom_range(0, 2)));
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (sb.pending_totals.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES * 2) @(negedge clock);
      if (sb.errors == 0 && sb.pending_totals.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
